FILE: design/assert_macros.svh
// Assertion macros used by the heap queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must follow from another in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/bhpq_pkg.sv
// Types and constants shared by the heap priority queue modules.
`default_nettype none

package bhpq_pkg;

    localparam int PRI_W  = 32;
    localparam int ELEM_W = 16;
    localparam int STAT_W = 2;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [ELEM_W-1:0]       elem;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_READ,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN_READ,
        S_DN_CMP,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    start_put;
        logic    start_get;
        logic    set_status;
        status_t status;
        logic    rd_parent;
        logic    rd_last;
        logic    load_last;
        logic    rd_children;
        logic    up_move;
        logic    dn_move;
        logic    place;
        logic    finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic up_less;
        logic has_child;
        logic pick_child;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/bhpq_ctrl.sv
// Controller state machine that sequences put and get requests.
`default_nettype none

module bhpq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_op,
    output logic               s_tready,
    input  wire bhpq_pkg::sts_t sts,
    output bhpq_pkg::cmd_t     cmd
);
    import bhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == OP_GET) begin
                        state_next = sts.empty ? S_FINISH : S_DN_LAST;
                    end else begin
                        state_next = sts.full ? S_FINISH : S_UP_READ;
                    end
                end
            end
            S_UP_READ: state_next = sts.pos_zero ? S_FINISH : S_UP_CMP;
            S_UP_CMP:  state_next = sts.up_less ? S_UP_READ : S_FINISH;
            S_DN_LAST: state_next = sts.empty ? S_FINISH : S_DN_LOAD;
            S_DN_LOAD: state_next = S_DN_READ;
            S_DN_READ: state_next = sts.has_child ? S_DN_CMP : S_FINISH;
            S_DN_CMP:  state_next = sts.pick_child ? S_DN_READ : S_FINISH;
            S_FINISH:  state_next = sts.out_free ? S_IDLE : S_FINISH;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item  = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    if (s_op == OP_GET) begin
                        if (sts.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.start_get = 1'b1;
                        end
                    end else begin
                        if (sts.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.start_put = 1'b1;
                        end
                    end
                end
            end
            S_UP_READ: begin
                if (sts.pos_zero) begin
                    cmd.place = 1'b1;
                end else begin
                    cmd.rd_parent = 1'b1;
                end
            end
            S_UP_CMP: begin
                if (sts.up_less) begin
                    cmd.up_move = 1'b1;
                end else begin
                    cmd.place = 1'b1;
                end
            end
            S_DN_LAST: begin
                cmd.rd_last = !sts.empty;
            end
            S_DN_LOAD: begin
                cmd.load_last = 1'b1;
            end
            S_DN_READ: begin
                if (sts.has_child) begin
                    cmd.rd_children = 1'b1;
                end else begin
                    cmd.place = 1'b1;
                end
            end
            S_DN_CMP: begin
                if (sts.pick_child) begin
                    cmd.dn_move = 1'b1;
                end else begin
                    cmd.place = 1'b1;
                end
            end
            S_FINISH: begin
                cmd.finish = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bhpq_dpath.sv
// Datapath: heap memory, hole position, compare logic and result register.
`default_nettype none
`include "assert_macros.svh"

module bhpq_dpath #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [bhpq_pkg::PRI_W-1:0]    in_pri,
    input  wire logic [bhpq_pkg::ELEM_W-1:0]   in_elem,
    input  wire bhpq_pkg::cmd_t                cmd,
    output bhpq_pkg::sts_t                     sts,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output bhpq_pkg::status_t                  out_status,
    output bhpq_pkg::entry_t                   out_got,
    output bhpq_pkg::entry_t                   out_best,
    output logic [CNT_W-1:0]                   out_count
);
    import bhpq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CHD_W = IDX_W + 2;

    entry_t mem [CAPACITY];

    entry_t             item_reg;
    entry_t             root_reg;
    entry_t             got_reg;
    entry_t             rd0_reg;
    entry_t             rd1_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   parent_reg;
    logic [IDX_W-1:0]   lc_reg;
    logic               rc_ok_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    entry_t             out_got_reg;
    entry_t             out_best_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic [CHD_W-1:0]   lc_ext;
    logic [CHD_W-1:0]   rc_ext;
    logic [CHD_W-1:0]   count_ext;
    logic [IDX_W-1:0]   parent_w;
    logic               rd_en0;
    logic               rd_en1;
    logic [IDX_W-1:0]   rd_addr0;
    logic [IDX_W-1:0]   rd_addr1;
    logic               wr_en;
    entry_t             wr_data;
    logic               lc_less;
    logic               rc_less;
    logic signed [PRI_W-1:0] cmp_pri;

    assign lc_ext    = {1'b0, pos_reg, 1'b1};
    assign rc_ext    = lc_ext + 1'b1;
    assign count_ext = CHD_W'(count_reg);
    assign parent_w  = (pos_reg - 1'b1) >> 1;

    // Children are picked left first; the right child wins only when it is
    // strictly below the smaller of the hole item and the left child.
    assign lc_less = rd0_reg.pri < item_reg.pri;
    assign cmp_pri = lc_less ? rd0_reg.pri : item_reg.pri;
    assign rc_less = rc_ok_reg && (rd1_reg.pri < cmp_pri);

    assign sts.full       = count_reg == CNT_W'(CAPACITY);
    assign sts.empty      = count_reg == '0;
    assign sts.pos_zero   = pos_reg == '0;
    assign sts.up_less    = item_reg.pri < rd0_reg.pri;
    assign sts.has_child  = lc_ext < count_ext;
    assign sts.pick_child = lc_less || rc_less;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign rd_en0   = cmd.rd_parent || cmd.rd_last || cmd.rd_children;
    assign rd_en1   = cmd.rd_children;
    assign rd_addr1 = rc_ext[IDX_W-1:0];

    always_comb begin
        rd_addr0 = lc_ext[IDX_W-1:0];
        if (cmd.rd_parent) begin
            rd_addr0 = parent_w;
        end else if (cmd.rd_last) begin
            rd_addr0 = count_reg[IDX_W-1:0];
        end
    end

    assign wr_en = cmd.up_move || cmd.dn_move || cmd.place;

    always_comb begin
        wr_data = item_reg;
        if (cmd.up_move) begin
            wr_data = rd0_reg;
        end else if (cmd.dn_move) begin
            wr_data = rc_less ? rd1_reg : rd0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pos_reg] <= wr_data;
        end
        if (rd_en0) begin
            rd0_reg <= mem[rd_addr0];
        end
        if (rd_en1) begin
            rd1_reg <= mem[rd_addr1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= {in_pri, in_elem};
            // A get takes the root at accept; every other request reports zero.
            got_reg  <= cmd.start_get ? root_reg : '0;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.start_put) begin
            pos_reg <= count_reg[IDX_W-1:0];
        end
        if (cmd.rd_parent) begin
            parent_reg <= parent_w;
        end
        if (cmd.rd_children) begin
            lc_reg    <= lc_ext[IDX_W-1:0];
            rc_ok_reg <= rc_ext < count_ext;
        end
        if (cmd.load_last) begin
            item_reg <= rd0_reg;
            pos_reg  <= '0;
        end
        if (cmd.up_move) begin
            pos_reg <= parent_reg;
        end
        if (cmd.dn_move) begin
            pos_reg <= rc_less ? lc_reg + 1'b1 : lc_reg;
        end
        // The root is mirrored in flops so results never need a memory read.
        if (wr_en && pos_reg == '0) begin
            root_reg <= wr_data;
        end
        if (cmd.finish) begin
            out_status_reg <= status_reg;
            out_got_reg    <= got_reg;
            out_best_reg   <= (count_reg == '0) ? '0 : root_reg;
            out_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start_put) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.start_get) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_got    = out_got_reg;
    assign out_best   = out_best_reg;
    assign out_count  = out_count_reg;

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `ASSERT_IMP(a_full_count, aclk, aresetn, out_valid_reg && out_status_reg == ST_FULL, out_count_reg == CNT_W'(CAPACITY), "full status without a full heap")
    `ASSERT_IMP(a_empty_zero, aclk, aresetn, out_valid_reg && out_status_reg == ST_EMPTY, out_count_reg == '0 && out_got_reg == '0, "empty status with entries or data")
    `ASSERT_IMP(a_no_rw_clash, aclk, aresetn, wr_en, !rd_en0 && !rd_en1, "heap memory read and written in one cycle")

endmodule

`default_nettype wire

FILE: design/binary_heap_priority_queue_top.sv
// Binary min-heap priority queue: a put inserts {priority, element}, a get removes
// the entry with the lowest signed priority (ties keep their heap places). Every
// request returns one result with its status, the removed entry, the new root and
// the entry count. The heap lives in one memory with a write port and two
// registered read ports; each heap level is a read state followed by a compare
// state. A put moves the new entry up towards the root and a get moves the last
// entry down from the root, at most log2(CAPACITY) levels (six at the default of
// 64). The next request is accepted in the cycle after the result is loaded,
// even while that result still waits in the output register. A put into a full
// heap is dropped with full status, a get on an empty heap returns empty status.
`default_nettype none

module binary_heap_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // priority_req [31:0], element [47:32]
    input  wire logic [47:0]       s_tdata,
    // operation [0]
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // status, got_element, got_priority, best_element, best_priority, entry_count
    output logic [((98 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
    import bhpq_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int OUT_W  = STAT_W + 2 * (ELEM_W + PRI_W) + CNT_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    cmd_t              cmd;
    sts_t              sts;
    status_t           out_status;
    entry_t            out_got;
    entry_t            out_best;
    logic [CNT_W-1:0]  out_count;

    bhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bhpq_dpath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_pri     (s_tdata[PRI_W-1:0]),
        .in_elem    (s_tdata[PRI_W+ELEM_W-1:PRI_W]),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_got    (out_got),
        .out_best   (out_best),
        .out_count  (out_count)
    );

    assign m_tdata = OUT_TW'({out_count, out_best.pri, out_best.elem,
                              out_got.pri, out_got.elem, out_status});

endmodule

`default_nettype wire

FILE: dv/heap_queue_checker.sv
// Checker that predicts the heap queue results and compares them with the block's output.
module heap_queue_checker
    import bhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [47:0]         s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [((98 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output int                  mismatch_count,
    output int                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct {
        status_t           status;
        logic [15:0]       got_elem;
        logic [31:0]       got_pri;
        logic [15:0]       best_elem;
        logic [31:0]       best_pri;
        logic [CNT_W-1:0]  count;
    } heap_result_t;

    entry_t       heap_mem [CAPACITY];
    int           heap_fill;
    heap_result_t expected_results [$];
    int           results_seen;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
        heap_fill       = 0;
        results_seen    = 0;
    end

    function automatic bit pri_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    task automatic swap_entries(input int a, input int b);
        entry_t tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endtask

    // Applies one request to the shadow heap and returns the result the block must give.
    task automatic predict_heap_step(input op_t op, input logic [31:0] pri,
                                     input logic [15:0] elem, output heap_result_t r);
        int pos;
        int up;
        int lc;
        int rc;
        int best;
        bit done;
        r.status   = ST_OK;
        r.got_elem = '0;
        r.got_pri  = '0;
        if (op == OP_PUT) begin
            if (heap_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                heap_mem[heap_fill].pri  = pri;
                heap_mem[heap_fill].elem = elem;
                heap_fill++;
                pos  = heap_fill - 1;
                done = 1'b0;
                while (pos > 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (pri_less(heap_mem[pos].pri, heap_mem[up].pri)) begin
                        swap_entries(pos, up);
                        pos = up;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.got_elem  = heap_mem[0].elem;
                r.got_pri   = heap_mem[0].pri;
                heap_fill--;
                heap_mem[0] = heap_mem[heap_fill];
                pos  = 0;
                done = 1'b0;
                while (!done) begin
                    best = pos;
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    // Left child is tested first; a tie never displaces the current pick.
                    if (lc < heap_fill && pri_less(heap_mem[lc].pri, heap_mem[best].pri))
                        best = lc;
                    if (rc < heap_fill && pri_less(heap_mem[rc].pri, heap_mem[best].pri))
                        best = rc;
                    if (best == pos) begin
                        done = 1'b1;
                    end else begin
                        swap_entries(pos, best);
                        pos = best;
                    end
                end
            end
        end
        if (heap_fill > 0) begin
            r.best_elem = heap_mem[0].elem;
            r.best_pri  = heap_mem[0].pri;
        end else begin
            r.best_elem = '0;
            r.best_pri  = '0;
        end
        r.count = heap_fill[CNT_W-1:0];
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] want);
        if (seen !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, want));
    endtask

    always @(posedge aclk) begin
        heap_result_t want;
        heap_result_t pred;
        if (!aresetn) begin
            heap_fill = 0;
            expected_results.delete();
        end else begin
            // The result leaving at this edge always belongs to an earlier request.
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", m_tdata[1:0], want.status);
                    check_field("got_element", m_tdata[17:2], want.got_elem);
                    check_field("got_priority", m_tdata[49:18], want.got_pri);
                    check_field("best_element", m_tdata[65:50], want.best_elem);
                    check_field("best_priority", m_tdata[97:66], want.best_pri);
                    check_field("entry_count", m_tdata[98 +: CNT_W], want.count);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                predict_heap_step(op_t'(s_tuser[0]), s_tdata[31:0], s_tdata[47:32], pred);
                expected_results.push_back(pred);
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

FILE: dv/binary_heap_priority_queue_top_tb.sv
// Testbench top for the binary heap priority queue: stimulus, stalls and the verdict.
module binary_heap_priority_queue_top_tb;
    import bhpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;
    localparam int RES_W    = ((98 + $clog2(CAPACITY + 1) + 7) / 8) * 8;
    localparam int TARGET_REQUESTS = 1000;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [47:0]      s_tdata  = '0;
    logic [0:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;

    int mismatch_count;
    int pending_results;
    int requests_sent = 0;
    int burst_left    = 0;
    int ready_hold    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    binary_heap_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    heap_queue_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // The receiver alternates long ready runs, stalls and cycle-by-cycle random ready.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    m_tready   <= 1'b1;
                    ready_hold <= $urandom_range(0, 40);
                end
                5, 6: begin
                    m_tready   <= 1'b0;
                    ready_hold <= $urandom_range(0, 20);
                end
                default: begin
                    m_tready   <= 1'($urandom_range(0, 1));
                    ready_hold <= 0;
                end
            endcase
        end
    end

    task automatic drop_valid(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Sends one request in the current burst; a new burst starts after a random gap.
    task automatic send_request(input op_t op, input logic [31:0] pri, input logic [15:0] elem);
        if (burst_left == 0) begin
            drop_valid($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {elem, pri};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 15) - 8;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return ($urandom_range(0, 7) - 4) << 16;
        endcase
    endfunction

    function automatic logic [15:0] pick_element();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic run_mixed(input int count, input int put_pct);
        repeat (count) begin
            if ($urandom_range(1, 100) <= put_pct)
                send_request(OP_PUT, pick_priority(), pick_element());
            else
                send_request(OP_GET, $urandom, pick_element());
        end
    endtask

    task automatic run_fill();
        repeat (CAPACITY + $urandom_range(2, 6))
            send_request(OP_PUT, pick_priority(), pick_element());
    endtask

    task automatic run_drain();
        repeat (CAPACITY + $urandom_range(2, 6))
            send_request(OP_GET, $urandom, pick_element());
    endtask

    // Many equal priorities so that ties decide most sift steps.
    task automatic run_ties(input int count);
        logic [31:0] pri;
        repeat (count) begin
            case ($urandom_range(0, 2))
                0: pri = 32'h0000_0000;
                1: pri = 32'h0001_0000;
                default: pri = 32'hFFFF_0000;
            endcase
            if ($urandom_range(0, 2) != 0)
                send_request(OP_PUT, pri, pick_element());
            else
                send_request(OP_GET, $urandom, pick_element());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty get, priority extremes, ties, drain to empty.
        send_request(OP_GET, 32'h0000_0000, 16'h0000);
        send_request(OP_PUT, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_PUT, 32'h8000_0000, 16'h0000);
        send_request(OP_PUT, 32'h0000_0000, 16'h1234);
        send_request(OP_PUT, 32'hFFFF_FFFF, 16'hAAAA);
        send_request(OP_PUT, 32'h8000_0000, 16'h5555);
        send_request(OP_PUT, 32'h0001_0000, 16'h8001);
        send_request(OP_PUT, 32'h7FFF_FFFF, 16'h0001);
        repeat (7) send_request(OP_GET, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_GET, 32'h0000_0000, 16'h0000);
        send_request(OP_PUT, 32'h0002_0000, 16'h0011);
        send_request(OP_PUT, 32'h0002_0000, 16'h0022);
        send_request(OP_PUT, 32'h0002_0000, 16'h0033);
        send_request(OP_PUT, 32'h0002_0000, 16'h0044);
        repeat (4) send_request(OP_GET, 32'h0000_0000, 16'h0000);
        wait_all_results();

        // A full heap and a full drain are reached at least once.
        run_fill();
        run_drain();

        while (requests_sent < TARGET_REQUESTS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_mixed($urandom_range(20, 60), $urandom_range(30, 70));
                4: run_mixed($urandom_range(20, 60), 90);
                5: run_fill();
                6: run_drain();
                7: run_ties($urandom_range(20, 40));
                default: begin
                    wait_all_results();
                    run_mixed($urandom_range(10, 30), 50);
                end
            endcase
        end

        wait_all_results();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
